FILE: rtl/rpsv_pkg.sv
// shared constants, types and codes for the regular polygon screen vertex block
// used by rpsv_alu and regular_polygon_screen_vertices
package rpsv_pkg;

  localparam int unsigned MAX_SIDES_DEF = 16;

  // field widths
  localparam int unsigned COORD_W = 24;
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SIDES_W = 5;
  localparam int unsigned RATIO_W = 24;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned PIXEL_W = 16;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // shared multiply-add unit
  localparam int unsigned OPA_W = 35;
  localparam int unsigned OPB_W = 31;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned RES_W = 48;

  // sine polynomial coefficients, Q30
  localparam logic [OPB_W-1:0] SIN_A = 31'd1686629713;
  localparam logic [OPB_W-1:0] SIN_B = 31'd693598668;
  localparam logic [OPB_W-1:0] SIN_C = 31'd85569305;
  localparam logic [OPB_W-1:0] SIN_D = 31'd5026994;
  localparam logic [OPB_W-1:0] SIN_E = 31'd172269;

  // reset values
  localparam logic [RATIO_W-1:0] RATIO_ONE = 24'd65536;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_WINDOW_HEIGHT,
    REG_ZOOM,
    REG_OFFSET_X,
    REG_OFFSET_Y
  } cfg_reg_e;

  // post shift and rounding of the multiply-add unit
  typedef enum logic [1:0] {
    SH_15,
    SH_16,
    SH_30,
    SH_45
  } shift_e;

  typedef struct packed {
    shift_e shift;
    logic   neg;
    logic   sub;
  } alu_op_t;

endpackage

FILE: rtl/rpsv_alu.sv
// shared multiply-add unit: registered product with rounding bias, then shift and add
// depends on rpsv_pkg
module rpsv_alu import rpsv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    mul_en_i,
  input  alu_op_t                 op_i,
  input  logic [OPA_W-1:0]        a_i,
  input  logic [OPB_W-1:0]        b_i,
  input  logic signed [RES_W-1:0] addend_i,
  output logic signed [RES_W-1:0] res_o
);

  logic [PROD_W-1:0] half;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;
  logic [RES_W-1:0]  shifted;
  logic [RES_W-1:0]  term_p;
  logic [RES_W-1:0]  term_a;

  always_comb begin
    case (op_i.shift)
      SH_15:   half = PROD_W'(1) << 14;
      SH_16:   half = PROD_W'(1) << 15;
      SH_45:   half = PROD_W'(1) << 44;
      default: half = '0;
    endcase
  end

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i) + half;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    case (op_i.shift)
      SH_15:   shifted = RES_W'(prod_q >> 15);
      SH_16:   shifted = RES_W'(prod_q >> 16);
      SH_30:   shifted = RES_W'(prod_q >> 30);
      default: shifted = RES_W'(prod_q >> 45);
    endcase
  end

  // addend +/- shifted product, or +/- shifted product minus addend
  assign term_p = op_i.neg ? ~shifted : shifted;
  assign term_a = op_i.sub ? ~addend_i : addend_i;
  assign res_o  = term_p + term_a + RES_W'(op_i.neg) + RES_W'(op_i.sub);

endmodule

FILE: rtl/regular_polygon_screen_vertices.sv
// A start request (start high while busy is low) takes one polygon and returns one result
// per vertex, vertex 0 first, each shown for a single cycle with result_valid_o high; the
// receiver cannot hold results off. A polygon keeps busy high through a bit-serial divide for
// the angle step, then through each vertex in turn on the one shared 35 x 31 multiply-add
// unit, which runs 18 operations per vertex (two sine polynomials, radius, scale and zoom)
// plus a magnitude step before each scale and zoom operation.
// Registers are written through cfg_valid_i / cfg_index_i / cfg_data_i, always ready.
// depends on rpsv_pkg and rpsv_alu
module regular_polygon_screen_vertices import rpsv_pkg::*; #(
  parameter int unsigned MAX_SIDES = MAX_SIDES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  center_x_i,
  input  logic signed [COORD_W-1:0]  center_y_i,
  input  logic [RADIUS_W-1:0]        radius_i,
  input  logic [ANGLE_W-1:0]         rotation_i,
  input  logic [SIDES_W-1:0]         sides_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [RATIO_W-1:0]         cfg_data_i,
  output logic                       result_valid_o,
  output logic signed [PIXEL_W-1:0]  screen_x_o,
  output logic signed [PIXEL_W-1:0]  screen_y_o,
  output logic [INDEX_W-1:0]         vertex_index_o,
  output logic                       last_vertex_o
);

  localparam int unsigned NW = $clog2(MAX_SIDES + 1);
  localparam int unsigned KW = $clog2(MAX_SIDES);
  localparam logic [4:0] DIV_FIRST = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_ADD,
    S_ABS,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_X2,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_P4,
    OP_SIN,
    OP_RAD,
    OP_X1,
    OP_XS,
    OP_Y1,
    OP_YS
  } op_e;

  function automatic logic [OPB_W-1:0] quarter_x(input logic [ANGLE_W-1:0] ang);
    logic [14:0] t;
    logic [14:0] u;
    t = {1'b0, ang[13:0]};
    u = ang[14] ? (15'h4000 - t) : t;
    return {u, 16'h0000};
  endfunction

  function automatic logic [PIXEL_W-1:0] to_pixel(input logic signed [45:0] v);
    logic signed [45:0] adj;
    logic signed [37:0] px;
    adj = v + (v[45] ? 46'sd255 : 46'sd0);
    px  = 38'(adj >>> 8);
    if (px > 38'sd32767) begin
      return 16'h7FFF;
    end else if (px < -38'sd32768) begin
      return 16'h8000;
    end else begin
      return px[15:0];
    end
  endfunction

  // configuration
  logic [RATIO_W-1:0]        scale_x_q;
  logic [RATIO_W-1:0]        scale_y_q;
  logic [HEIGHT_W-1:0]       window_height_q;
  logic [RATIO_W-1:0]        zoom_q;
  logic signed [COORD_W-1:0] offset_x_q;
  logic signed [COORD_W-1:0] offset_y_q;

  // sequencer
  state_e          state_q;
  op_e             op_q;
  logic            cs_q;
  logic [KW-1:0]   k_q;
  logic [4:0]      dcnt_q;
  logic            result_valid_q;
  logic [PIXEL_W-1:0] screen_x_q;
  logic [PIXEL_W-1:0] screen_y_q;
  logic [INDEX_W-1:0] vertex_index_q;
  logic            last_vertex_q;

  // datapath
  logic signed [COORD_W-1:0] cx_q;
  logic signed [COORD_W-1:0] cy_q;
  logic [RADIUS_W-1:0]       rad_q;
  logic [ANGLE_W-1:0]        rot_q;
  logic [NW-1:0]             n_q;
  logic [NW-1:0]             rem_q;
  logic [15:0]               dq_q;
  logic [15:0]               step_q;
  logic [NW:0]               srem_q;
  logic [ANGLE_W-1:0]        ang_q;
  logic [OPB_W-1:0]          x_q;
  logic                      qneg_q;
  logic [OPB_W-1:0]          x2_q;
  logic [OPB_W-1:0]          acc_q;
  logic [16:0]               s_q;
  logic signed [26:0]        wx_q;
  logic signed [26:0]        wy_q;
  logic signed [35:0]        t_q;
  logic signed [45:0]        xs_q;
  logic signed [45:0]        ys_q;
  logic [OPA_W-1:0]          mag_q;
  logic                      mneg_q;

  logic [NW-1:0]             n_clamp;
  logic                      accept;
  logic                      last;
  logic                      begin_vertex;
  logic [NW:0]               trial;
  logic                      div_ge;
  logic [NW-1:0]             rem_next;
  logic [NW+1:0]             r_sum;
  logic [NW+1:0]             two_n;
  logic                      step_ge;
  logic [ANGLE_W-1:0]        ang_now;
  logic [ANGLE_W-1:0]        cos_ang;
  logic signed [RES_W-1:0]   abs_src;
  logic signed [RES_W-1:0]   abs_val;

  alu_op_t                   alu_op;
  logic [OPA_W-1:0]          alu_a;
  logic [OPB_W-1:0]          alu_b;
  logic signed [RES_W-1:0]   alu_addend;
  logic signed [RES_W-1:0]   alu_res;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (sides_i < 5'd3) begin
      n_clamp = NW'(3);
    end else if (int'(sides_i) > int'(MAX_SIDES)) begin
      n_clamp = NW'(MAX_SIDES);
    end else begin
      n_clamp = NW'(sides_i);
    end
  end

  assign last = ((NW'(k_q) + NW'(1)) == n_q);
  assign begin_vertex = ((state_q == S_DIV) && (dcnt_q == '0)) ||
                        ((state_q == S_OUT) && !last);

  // 65536 / n, one dividend bit per cycle
  assign trial    = {rem_q, (dcnt_q == DIV_FIRST)};
  assign div_ge   = (trial >= {1'b0, n_q});
  assign rem_next = div_ge ? NW'(trial - {1'b0, n_q}) : NW'(trial);

  // round(k * 65536 / n) kept as quotient and remainder over 2n
  assign r_sum   = (NW+2)'(srem_q) + (NW+2)'({rem_q, 1'b0});
  assign two_n   = (NW+2)'({n_q, 1'b0});
  assign step_ge = (r_sum >= two_n);

  assign ang_now = rot_q + step_q;
  assign cos_ang = ang_now + 16'h4000;

  always_comb begin
    case (op_q)
      OP_X1:   abs_src = RES_W'(wx_q);
      OP_Y1:   abs_src = RES_W'(wy_q);
      default: abs_src = RES_W'(t_q);
    endcase
    abs_val = abs_src[RES_W-1] ? -abs_src : abs_src;
  end

  always_comb begin
    alu_op     = '{shift: SH_30, neg: 1'b0, sub: 1'b0};
    alu_a      = OPA_W'(x2_q);
    alu_b      = acc_q;
    alu_addend = '0;
    case (op_q)
      OP_X2: begin
        alu_a = OPA_W'(x_q);
        alu_b = x_q;
      end
      OP_P1: begin
        alu_b      = SIN_E;
        alu_op.neg = 1'b1;
        alu_addend = RES_W'(SIN_D);
      end
      OP_P2: begin
        alu_op.neg = 1'b1;
        alu_addend = RES_W'(SIN_C);
      end
      OP_P3: begin
        alu_op.neg = 1'b1;
        alu_addend = RES_W'(SIN_B);
      end
      OP_P4: begin
        alu_op.neg = 1'b1;
        alu_addend = RES_W'(SIN_A);
      end
      OP_SIN: begin
        alu_a        = OPA_W'(x_q);
        alu_op.shift = SH_45;
      end
      OP_RAD: begin
        alu_a        = OPA_W'(s_q);
        alu_b        = OPB_W'(rad_q);
        alu_op.shift = SH_15;
        alu_op.neg   = qneg_q;
        alu_addend   = cs_q ? RES_W'(cy_q) : RES_W'(cx_q);
      end
      OP_X1: begin
        alu_a        = mag_q;
        alu_b        = OPB_W'(scale_x_q);
        alu_op.shift = SH_16;
        alu_op.neg   = mneg_q;
      end
      OP_XS: begin
        alu_a        = mag_q;
        alu_b        = OPB_W'(zoom_q);
        alu_op.shift = SH_16;
        alu_op.neg   = mneg_q;
        alu_op.sub   = 1'b1;
        alu_addend   = RES_W'(offset_x_q);
      end
      OP_Y1: begin
        alu_a        = mag_q;
        alu_b        = OPB_W'(scale_y_q);
        alu_op.shift = SH_16;
        alu_op.neg   = !mneg_q;
        alu_addend   = RES_W'({window_height_q, 8'h00});
      end
      OP_YS: begin
        alu_a        = mag_q;
        alu_b        = OPB_W'(zoom_q);
        alu_op.shift = SH_16;
        alu_op.neg   = mneg_q;
        alu_op.sub   = 1'b1;
        alu_addend   = RES_W'(offset_y_q);
      end
      default: begin
        alu_a = OPA_W'(x2_q);
      end
    endcase
  end

  rpsv_alu u_alu (
    .clk_i    (clk_i),
    .mul_en_i (state_q == S_MUL),
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .addend_i (alu_addend),
    .res_o    (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q       <= RATIO_ONE;
      scale_y_q       <= RATIO_ONE;
      window_height_q <= HEIGHT_RST;
      zoom_q          <= RATIO_ONE;
      offset_x_q      <= '0;
      offset_y_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCALE_X:       scale_x_q       <= cfg_data_i;
        REG_SCALE_Y:       scale_y_q       <= cfg_data_i;
        REG_WINDOW_HEIGHT: window_height_q <= cfg_data_i[HEIGHT_W-1:0];
        REG_ZOOM:          zoom_q          <= cfg_data_i;
        REG_OFFSET_X:      offset_x_q      <= cfg_data_i;
        REG_OFFSET_Y:      offset_y_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      op_q           <= OP_X2;
      cs_q           <= 1'b0;
      k_q            <= '0;
      dcnt_q         <= '0;
      result_valid_q <= 1'b0;
      screen_x_q     <= '0;
      screen_y_q     <= '0;
      vertex_index_q <= '0;
      last_vertex_q  <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_DIV;
            dcnt_q  <= DIV_FIRST;
            k_q     <= '0;
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q - 5'd1;
          if (dcnt_q == '0) begin
            state_q <= S_MUL;
            op_q    <= OP_X2;
            cs_q    <= 1'b0;
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          case (op_q)
            OP_X2: begin
              op_q    <= OP_P1;
              state_q <= S_MUL;
            end
            OP_P1: begin
              op_q    <= OP_P2;
              state_q <= S_MUL;
            end
            OP_P2: begin
              op_q    <= OP_P3;
              state_q <= S_MUL;
            end
            OP_P3: begin
              op_q    <= OP_P4;
              state_q <= S_MUL;
            end
            OP_P4: begin
              op_q    <= OP_SIN;
              state_q <= S_MUL;
            end
            OP_SIN: begin
              op_q    <= OP_RAD;
              state_q <= S_MUL;
            end
            OP_RAD: begin
              if (!cs_q) begin
                cs_q    <= 1'b1;
                op_q    <= OP_X2;
                state_q <= S_MUL;
              end else begin
                op_q    <= OP_X1;
                state_q <= S_ABS;
              end
            end
            OP_X1: begin
              op_q    <= OP_XS;
              state_q <= S_ABS;
            end
            OP_XS: begin
              op_q    <= OP_Y1;
              state_q <= S_ABS;
            end
            OP_Y1: begin
              op_q    <= OP_YS;
              state_q <= S_ABS;
            end
            default: begin
              state_q <= S_OUT;
            end
          endcase
        end
        S_ABS: begin
          state_q <= S_MUL;
        end
        S_OUT: begin
          result_valid_q <= 1'b1;
          screen_x_q     <= to_pixel(xs_q);
          screen_y_q     <= to_pixel(ys_q);
          vertex_index_q <= INDEX_W'(k_q);
          last_vertex_q  <= last;
          k_q            <= k_q + KW'(1);
          if (last) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_MUL;
            op_q    <= OP_X2;
            cs_q    <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q   <= center_x_i;
      cy_q   <= center_y_i;
      rad_q  <= radius_i;
      rot_q  <= rotation_i + 16'h2000;
      n_q    <= n_clamp;
      rem_q  <= '0;
      dq_q   <= '0;
      step_q <= '0;
      srem_q <= (NW+1)'(n_clamp);
    end
    if (state_q == S_DIV) begin
      rem_q <= rem_next;
      dq_q  <= {dq_q[14:0], div_ge};
    end
    // cosine goes first
    if (begin_vertex) begin
      ang_q  <= ang_now;
      x_q    <= quarter_x(cos_ang);
      qneg_q <= cos_ang[15];
    end
    if (state_q == S_ABS) begin
      mag_q  <= OPA_W'(abs_val);
      mneg_q <= abs_val != abs_src;
    end
    if (state_q == S_ADD) begin
      case (op_q)
        OP_X2:  x2_q <= alu_res[OPB_W-1:0];
        OP_SIN: s_q  <= alu_res[16:0];
        OP_RAD: begin
          if (cs_q) begin
            wy_q <= alu_res[26:0];
          end else begin
            wx_q   <= alu_res[26:0];
            x_q    <= quarter_x(ang_q);
            qneg_q <= ang_q[15];
            srem_q <= (NW+1)'(step_ge ? (r_sum - two_n) : r_sum);
            step_q <= step_q + dq_q + 16'(step_ge);
          end
        end
        OP_X1:  t_q  <= alu_res[35:0];
        OP_XS:  xs_q <= alu_res[45:0];
        OP_Y1:  t_q  <= alu_res[35:0];
        OP_YS:  ys_q <= alu_res[45:0];
        default: acc_q <= alu_res[OPB_W-1:0];
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign screen_x_o     = screen_x_q;
  assign screen_y_o     = screen_y_q;
  assign vertex_index_o = vertex_index_q;
  assign last_vertex_o  = last_vertex_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_vertex_o |-> busy)
    else $error("block idle before the final vertex");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_vertex_o |-> !busy)
    else $error("block still busy after the final vertex");

endmodule
